>>> sv/action_fifo_with_admission_and_flush_macros.svh
// ----------------------------------------------------------------------------
// action fifo assertion macros
// shared property forms for the checker, clocked on i_clk, off in reset
// ----------------------------------------------------------------------------
`ifndef ACTION_FIFO_WITH_ADMISSION_AND_FLUSH_MACROS_SVH
`define ACTION_FIFO_WITH_ADMISSION_AND_FLUSH_MACROS_SVH

// same-cycle implication
`define AFF_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AFF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/aff_pkg.sv
// ----------------------------------------------------------------------------
// aff_pkg
// request codes, word formats and control types of the action fifo
// ----------------------------------------------------------------------------
package aff_pkg;

    localparam int ID_W        = 8;
    localparam int COUNT_OUT_W = 5;

    typedef enum logic [1:0] {
        REQ_ADD     = 2'd0,
        REQ_CANCEL  = 2'd1,
        REQ_FLUSH   = 2'd2,
        REQ_ADVANCE = 2'd3
    } t_req_type;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    typedef struct packed {
        t_req_type         req_type;
        logic [ID_W-1:0]   action_id;
        logic              action_present;
        logic              only_when_idle;
        logic              walkable;
        logic              current_running;
    } t_req;

    typedef struct packed {
        logic                   stop_valid;
        logic [ID_W-1:0]        stop_id;
        logic                   accepted;
        logic                   current_valid;
        logic [ID_W-1:0]        current_id;
        logic [COUNT_OUT_W-1:0] queued_count;
        logic                   last;
    } t_res;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic            walk;
    } t_entry;

    typedef struct packed {
        logic   shift;
        logic   wr_en;
        t_entry wdata;
    } t_chain_ctl;

endpackage

>>> sv/aff_stream_if.sv
// ----------------------------------------------------------------------------
// aff_stream_if
// valid/ready channel carrying one word of type T
// ----------------------------------------------------------------------------
interface aff_stream_if #(parameter type T = logic) ();

    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

>>> sv/aff_cell.sv
// ----------------------------------------------------------------------------
// aff_cell
// one queue slot: loads a new entry, takes its neighbor's, or holds
// ----------------------------------------------------------------------------
module aff_cell import aff_pkg::*; (
    input  logic   i_clk,
    input  logic   i_shift,
    input  logic   i_sel,
    input  t_entry i_next,
    input  t_entry i_wdata,
    output t_entry o_entry
);

    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        priority if (i_sel) begin
            n_entry = i_wdata;
        end else if (i_shift) begin
            n_entry = i_next;
        end else begin
            n_entry = r_entry;
        end
    end

    // contents are undefined until written, no reset
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

>>> sv/aff_chain.sv
// ----------------------------------------------------------------------------
// aff_chain
// row of queue cells, head at cell 0, everything moves one step toward it
// ----------------------------------------------------------------------------
module aff_chain import aff_pkg::*; #(
    parameter int DEPTH = 16,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  t_chain_ctl       i_ctl,
    input  logic [IDX_W-1:0] i_wr_idx,
    output t_entry           o_head
);

    t_entry w_entry [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_entry w_next;
        logic   w_sel;

        if (g == DEPTH - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_body
            assign w_next = w_entry[g+1];
        end

        assign w_sel = i_ctl.wr_en && (i_wr_idx == IDX_W'(g));

        aff_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (i_ctl.shift),
            .i_sel   (w_sel),
            .i_next  (w_next),
            .i_wdata (i_ctl.wdata),
            .o_entry (w_entry[g])
        );
    end

    assign o_head = w_entry[0];

endmodule

>>> sv/action_fifo_with_admission_and_flush.sv
// ----------------------------------------------------------------------------
// action_fifo_with_admission_and_flush: bounded action queue plus current slot
// add/advance: result registered the cycle after accept; one word per cycle while idle and unstalled
// cancel/flush: scan of queue and current slot, a stop word per stopped action, else one status word
// sync active-low reset empties queue and current slot, output goes invalid
// ----------------------------------------------------------------------------
module action_fifo_with_admission_and_flush import aff_pkg::*; #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    aff_stream_if.sink    i_req,
    aff_stream_if.source  o_res
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int STP_W = $clog2(QUEUE_DEPTH + 2);

    // sequencer state
    t_state           r_state,      n_state;
    // queue occupancy and number of walkable entries in it
    logic [CNT_W-1:0] r_count,      n_count;
    logic [CNT_W-1:0] r_walk_cnt,   n_walk_cnt;
    // current slot
    logic             r_cur_valid,  n_cur_valid;
    logic [ID_W-1:0]  r_cur_id,     n_cur_id;
    logic             r_cur_walk,   n_cur_walk;
    // walk bookkeeping for cancel / flush
    logic             r_is_cancel,  n_is_cancel;
    logic             r_cur_pend,   n_cur_pend;
    logic [ID_W-1:0]  r_stop_id,    n_stop_id;
    logic [CNT_W-1:0] r_scan_left,  n_scan_left;
    logic [CNT_W-1:0] r_kept,       n_kept;
    logic [STP_W-1:0] r_stops_left, n_stops_left;
    // output register
    logic             r_out_valid,  n_out_valid;
    t_res             r_out,        n_out;

    t_chain_ctl       w_ctl;
    logic [IDX_W-1:0] w_wr_idx;
    t_entry           w_head;

    logic             w_out_free;
    logic             w_in_ready;
    logic             w_in_fire;

    assign w_out_free = !r_out_valid || o_res.ready;
    assign w_in_ready = (r_state == ST_IDLE) && w_out_free;
    assign w_in_fire  = i_req.valid && w_in_ready;

    assign i_req.ready = w_in_ready;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    aff_chain #(
        .DEPTH (QUEUE_DEPTH)
    ) u_chain (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_wr_idx (w_wr_idx),
        .o_head   (w_head)
    );

    always_comb begin
        t_entry           in_entry;
        t_entry           head_sel;
        logic             is_add;
        logic             busy;
        logic             push;
        logic             do_adv;
        logic             hold_cur;
        logic             avail;
        logic             pop;
        logic             cur_stop;
        logic [CNT_W-1:0] q_stops;
        logic [STP_W-1:0] n_stops;
        logic [CNT_W-1:0] idx_sum;
        logic             emit;
        t_res             res;

        n_state      = r_state;
        n_count      = r_count;
        n_walk_cnt   = r_walk_cnt;
        n_cur_valid  = r_cur_valid;
        n_cur_id     = r_cur_id;
        n_cur_walk   = r_cur_walk;
        n_is_cancel  = r_is_cancel;
        n_cur_pend   = r_cur_pend;
        n_stop_id    = r_stop_id;
        n_scan_left  = r_scan_left;
        n_kept       = r_kept;
        n_stops_left = r_stops_left;

        w_ctl    = '0;
        w_wr_idx = '0;
        emit     = 1'b0;
        res      = '0;

        in_entry.id   = i_req.data.action_id;
        in_entry.walk = i_req.data.walkable;
        // with an empty queue a pushed entry is the head it pops
        head_sel = (r_count == '0) ? in_entry : w_head;

        is_add   = (i_req.data.req_type == REQ_ADD);
        busy     = (r_count != '0) || r_cur_valid;
        push     = 1'b0;
        do_adv   = 1'b0;
        hold_cur = r_cur_valid && i_req.data.current_running;
        avail    = 1'b0;
        pop      = 1'b0;
        cur_stop = 1'b0;
        q_stops  = '0;
        n_stops  = '0;
        idx_sum  = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    unique case (i_req.data.req_type)
                        REQ_ADD, REQ_ADVANCE: begin
                            push   = is_add && i_req.data.action_present
                                     && (r_count < CNT_W'(QUEUE_DEPTH))
                                     && !(i_req.data.only_when_idle && busy);
                            do_adv = !is_add || push;
                            avail  = (r_count != '0) || push;
                            pop    = do_adv && !hold_cur && avail;

                            if (do_adv && !hold_cur) begin
                                n_cur_valid = avail;
                            end
                            if (pop) begin
                                n_cur_id   = head_sel.id;
                                n_cur_walk = head_sel.walk;
                            end

                            n_count    = r_count + CNT_W'(push) - CNT_W'(pop);
                            n_walk_cnt = r_walk_cnt + CNT_W'(push && in_entry.walk)
                                         - CNT_W'(pop && head_sel.walk);

                            // push lands at the tail, one lower if the head leaves
                            w_ctl.shift = pop && (r_count != '0);
                            w_ctl.wr_en = push && !(pop && (r_count == '0));
                            w_ctl.wdata = in_entry;
                            idx_sum     = pop ? (r_count - CNT_W'(1)) : r_count;
                            w_wr_idx    = idx_sum[IDX_W-1:0];

                            emit              = 1'b1;
                            res.accepted      = push;
                            res.current_valid = n_cur_valid;
                            res.current_id    = n_cur_valid ? n_cur_id : '0;
                            res.queued_count  = COUNT_OUT_W'(n_count);
                            res.last          = 1'b1;
                        end
                        REQ_CANCEL, REQ_FLUSH: begin
                            cur_stop = r_cur_valid
                                       && (!is_add && (i_req.data.req_type == REQ_CANCEL)
                                           || !r_cur_walk);
                            q_stops  = (i_req.data.req_type == REQ_CANCEL)
                                       ? r_count : (r_count - r_walk_cnt);
                            n_stops  = STP_W'(q_stops) + STP_W'(cur_stop);

                            if (n_stops == '0) begin
                                // nothing to stop: single status word
                                emit              = 1'b1;
                                res.current_valid = r_cur_valid;
                                res.current_id    = r_cur_valid ? r_cur_id : '0;
                                res.queued_count  = COUNT_OUT_W'(r_count);
                                res.last          = 1'b1;
                            end else begin
                                n_is_cancel  = (i_req.data.req_type == REQ_CANCEL);
                                n_cur_pend   = cur_stop;
                                n_stop_id    = r_cur_id;
                                n_cur_valid  = r_cur_valid && !cur_stop;
                                n_scan_left  = r_count;
                                n_kept       = '0;
                                n_stops_left = n_stops;
                                // status words carry the end state from the start
                                if (i_req.data.req_type == REQ_CANCEL) begin
                                    n_count    = '0;
                                    n_walk_cnt = '0;
                                end else begin
                                    n_count    = r_walk_cnt;
                                end
                                n_state = ST_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                res.stop_valid    = 1'b1;
                res.current_valid = r_cur_valid;
                res.current_id    = r_cur_valid ? r_cur_id : '0;
                res.queued_count  = COUNT_OUT_W'(r_count);
                res.last          = (r_stops_left == STP_W'(1));

                priority if (r_cur_pend
                             && (!r_is_cancel || (r_scan_left == '0))) begin
                    // flush stops the current action first, cancel last
                    if (w_out_free) begin
                        emit         = 1'b1;
                        res.stop_id  = r_stop_id;
                        n_cur_pend   = 1'b0;
                        n_stops_left = r_stops_left - STP_W'(1);
                    end
                end else if (r_scan_left != '0) begin
                    if (r_is_cancel || !w_head.walk) begin
                        if (w_out_free) begin
                            emit         = 1'b1;
                            res.stop_id  = w_head.id;
                            w_ctl.shift  = 1'b1;
                            n_scan_left  = r_scan_left - CNT_W'(1);
                            n_stops_left = r_stops_left - STP_W'(1);
                        end
                    end else begin
                        // walkable entry goes behind the ones already kept
                        w_ctl.shift = 1'b1;
                        w_ctl.wr_en = 1'b1;
                        w_ctl.wdata = w_head;
                        idx_sum     = r_scan_left - CNT_W'(1) + r_kept;
                        w_wr_idx    = idx_sum[IDX_W-1:0];
                        n_kept      = r_kept + CNT_W'(1);
                        n_scan_left = r_scan_left - CNT_W'(1);
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (emit) begin
            n_out_valid = 1'b1;
            n_out       = res;
        end else begin
            n_out_valid = r_out_valid && !o_res.ready;
            n_out       = r_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_count      <= '0;
            r_walk_cnt   <= '0;
            r_cur_valid  <= 1'b0;
            r_cur_walk   <= 1'b0;
            r_cur_pend   <= 1'b0;
            r_scan_left  <= '0;
            r_kept       <= '0;
            r_stops_left <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_walk_cnt   <= n_walk_cnt;
            r_cur_valid  <= n_cur_valid;
            r_cur_walk   <= n_cur_walk;
            r_cur_pend   <= n_cur_pend;
            r_scan_left  <= n_scan_left;
            r_kept       <= n_kept;
            r_stops_left <= n_stops_left;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cur_id    <= n_cur_id;
        r_is_cancel <= n_is_cancel;
        r_stop_id   <= n_stop_id;
        r_out       <= n_out;
    end

endmodule

>>> sv/aff_checker.sv
// ----------------------------------------------------------------------------
// aff_checker
// port-level checks on the result channel of the action fifo
// ----------------------------------------------------------------------------
`include "action_fifo_with_admission_and_flush_macros.svh"

module aff_checker import aff_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_out_valid,
    input logic i_out_ready,
    input t_res i_out_data
);

    // a stalled word stays put
    `AFF_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data), "result word changed while stalled")

    // a word without a stop is always the only word of its request
    `AFF_ASSERT_IMPL(a_nostop_last, i_out_valid && !i_out_data.stop_valid, i_out_data.last, "status word not marked last")

    // an accepted add never reports a stop
    `AFF_ASSERT_IMPL(a_acc_nostop, i_out_valid && i_out_data.accepted, !i_out_data.stop_valid && i_out_data.last, "accepted add carries a stop")

    // empty current slot reads as handle zero
    `AFF_ASSERT_IMPL(a_cur_zero, i_out_valid && !i_out_data.current_valid, i_out_data.current_id == '0, "empty current slot shows a handle")

endmodule

bind action_fifo_with_admission_and_flush aff_checker u_aff_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench for action_fifo_with_admission_and_flush
// sends add, advance, cancel and flush requests over the request channel,
// predicts every result word from a shadow queue and current slot, and
// compares each word taken from the result channel with the oldest prediction
// ----------------------------------------------------------------------------
module testbench;
    import aff_pkg::*;

    localparam int QUEUE_DEPTH    = 16;
    localparam int TOTAL_REQUESTS = 460;
    localparam int MAX_GAP        = 6;
    localparam int MODE_SPAN      = 24;    // words between idling mode changes
    localparam int HOLD_AT_WORD   = 150;   // result word count that starts the long hold
    localparam int LONG_HOLD      = 160;   // cycles the result side stays not ready
    localparam int SETTLE_CYCLES  = 40;    // longest scan of a cancel or flush, with margin
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PRINT_CAP      = 100;

    // a row of the directed table: the result is typed in only where marked
    typedef struct {
        t_req req;
        bit   typed;
        t_res want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    aff_stream_if #(.T(t_req)) req_if ();
    aff_stream_if #(.T(t_res)) res_if ();

    action_fifo_with_admission_and_flush #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_res  (res_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow of the queue and the current slot
    logic [ID_W-1:0] shadow_id   [QUEUE_DEPTH];
    logic            shadow_walk [QUEUE_DEPTH];
    int unsigned     shadow_count;
    logic            slot_valid;
    logic [ID_W-1:0] slot_id;
    logic            slot_walk;

    t_res step_words[$];       // words caused by the latest request
    t_res expected_words[$];   // words still owed by the block
    t_row plan[$];

    int  n_sent;
    int  n_got;
    int  n_mismatch;
    int  stall_cycles;
    bit  sender_quiet;
    bit  receiver_quiet;

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // a word carries the slot and the count as they stand after the step
    function automatic t_res slot_word(logic stop, logic [ID_W-1:0] id, logic acc,
                                       logic fin);
        t_res r;
        r.stop_valid    = stop;
        r.stop_id       = id;
        r.accepted      = acc;
        r.current_valid = slot_valid;
        r.current_id    = slot_valid ? slot_id : '0;
        r.queued_count  = shadow_count[COUNT_OUT_W-1:0];
        r.last          = fin;
        return r;
    endfunction

    // a running current action stays; otherwise it is dropped without a stop
    function automatic void advance_slot(logic running);
        if (slot_valid && running)
            return;
        slot_valid = 1'b0;
        slot_id    = '0;
        slot_walk  = 1'b0;
        if (shadow_count > 0) begin
            slot_valid = 1'b1;
            slot_id    = shadow_id[0];
            slot_walk  = shadow_walk[0];
            for (int i = 1; i < shadow_count; i++) begin
                shadow_id[i-1]   = shadow_id[i];
                shadow_walk[i-1] = shadow_walk[i];
            end
            shadow_count--;
        end
    endfunction

    function automatic void predict_request(t_req w);
        logic [ID_W-1:0] stopped[$];
        int unsigned     kept;
        logic            acc;
        step_words.delete();
        acc = 1'b0;
        case (w.req_type)
            REQ_ADD, REQ_ADVANCE: begin
                if (w.req_type == REQ_ADVANCE) begin
                    advance_slot(w.current_running);
                end else if (w.action_present && shadow_count < QUEUE_DEPTH &&
                             !(w.only_when_idle && (shadow_count > 0 || slot_valid))) begin
                    shadow_id[shadow_count]   = w.action_id;
                    shadow_walk[shadow_count] = w.walkable;
                    shadow_count++;
                    acc = 1'b1;
                    advance_slot(w.current_running);
                end
                step_words.push_back(slot_word(1'b0, '0, acc, 1'b1));
                return;
            end
            REQ_CANCEL: begin
                // queued entries in order, then the current one
                for (int i = 0; i < shadow_count; i++)
                    stopped.push_back(shadow_id[i]);
                shadow_count = 0;
                if (slot_valid)
                    stopped.push_back(slot_id);
                slot_valid = 1'b0;
                slot_id    = '0;
                slot_walk  = 1'b0;
            end
            REQ_FLUSH: begin
                if (slot_valid && !slot_walk) begin
                    stopped.push_back(slot_id);
                    slot_valid = 1'b0;
                    slot_id    = '0;
                    slot_walk  = 1'b0;
                end
                // walkable entries close up in order
                kept = 0;
                for (int i = 0; i < shadow_count; i++) begin
                    if (shadow_walk[i]) begin
                        shadow_id[kept]   = shadow_id[i];
                        shadow_walk[kept] = 1'b1;
                        kept++;
                    end else begin
                        stopped.push_back(shadow_id[i]);
                    end
                end
                shadow_count = kept;
            end
        endcase
        if (stopped.size() == 0)
            step_words.push_back(slot_word(1'b0, '0, 1'b0, 1'b1));
        foreach (stopped[k])
            step_words.push_back(slot_word(1'b1, stopped[k], 1'b0, k == stopped.size() - 1));
    endfunction

    // ------------------------------------------------------------------------
    // word builders
    // ------------------------------------------------------------------------

    function automatic t_req req_word(t_req_type kind, logic [ID_W-1:0] id, logic present,
                                      logic idle_only, logic walk, logic running);
        t_req w;
        w.req_type        = kind;
        w.action_id       = id;
        w.action_present  = present;
        w.only_when_idle  = idle_only;
        w.walkable        = walk;
        w.current_running = running;
        return w;
    endfunction

    // every field but the kind random, so ignored fields toggle too
    function automatic t_req rand_req(t_req_type kind);
        return req_word(kind, ID_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)));
    endfunction

    function automatic t_res res_word(logic stop, logic [ID_W-1:0] sid, logic acc,
                                      logic cv, logic [ID_W-1:0] cid,
                                      logic [COUNT_OUT_W-1:0] cnt, logic fin);
        t_res r;
        r.stop_valid    = stop;
        r.stop_id       = sid;
        r.accepted      = acc;
        r.current_valid = cv;
        r.current_id    = cid;
        r.queued_count  = cnt;
        r.last          = fin;
        return r;
    endfunction

    function automatic void add_row(t_req r, bit typed, t_res want);
        plan.push_back('{r, typed, want});
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        n_mismatch++;
        if (n_mismatch <= PRINT_CAP)
            $display("mismatch at %0t, result word %0d: %s got %0h want %0h",
                     $time, n_got, what, got, want);
    endtask

    task automatic check_word(t_res got);
        t_res want;
        if (expected_words.size() == 0) begin
            report("word with nothing expected", 32'(got), '0);
            return;
        end
        want = expected_words.pop_front();
        if (got.stop_valid !== want.stop_valid)
            report("stop_valid", 32'(got.stop_valid), 32'(want.stop_valid));
        if (got.stop_id !== want.stop_id)
            report("stop_id", 32'(got.stop_id), 32'(want.stop_id));
        if (got.accepted !== want.accepted)
            report("accepted", 32'(got.accepted), 32'(want.accepted));
        if (got.current_valid !== want.current_valid)
            report("current_valid", 32'(got.current_valid), 32'(want.current_valid));
        if (got.current_id !== want.current_id)
            report("current_id", 32'(got.current_id), 32'(want.current_id));
        if (got.queued_count !== want.queued_count)
            report("queued_count", 32'(got.queued_count), 32'(want.queued_count));
        if (got.last !== want.last)
            report("last", 32'(got.last), 32'(want.last));
    endtask

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------

    // called at a rising edge; returns at the edge where the word is taken
    task automatic send_request(t_req w, bit typed, t_res want);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= w;
        // ready is looked at mid-cycle, where nothing moves
        do @(negedge i_clk); while (!req_if.ready);
        @(posedge i_clk);
        predict_request(w);
        if (typed && step_words.size() == 1)
            expected_words.push_back(want);
        else
            foreach (step_words[k])
                expected_words.push_back(step_words[k]);
        n_sent++;
        if (n_sent % MODE_SPAN == 0)
            sender_quiet = ($urandom_range(0, 3) == 0);
    endtask

    task automatic load_directed_rows();
        // empty block: advance, cancel and flush leave nothing and stop nothing
        add_row(req_word(REQ_ADVANCE, 8'hFF, 1, 1, 1, 0), 1, res_word(0, 0, 0, 0, 0, 0, 1));
        add_row(req_word(REQ_CANCEL,  8'hFF, 1, 1, 1, 1), 1, res_word(0, 0, 0, 0, 0, 0, 1));
        add_row(req_word(REQ_FLUSH,   8'hFF, 1, 1, 1, 1), 1, res_word(0, 0, 0, 0, 0, 0, 1));
        // null add is dropped
        add_row(req_word(REQ_ADD, 8'hFF, 0, 0, 1, 0), 1, res_word(0, 0, 0, 0, 0, 0, 1));
        // lowest handle goes straight to the current slot
        add_row(req_word(REQ_ADD, 8'h00, 1, 0, 0, 0), 1, res_word(0, 0, 1, 1, 8'h00, 0, 1));
        // idle-only add while busy is rejected
        add_row(req_word(REQ_ADD, 8'hFF, 1, 1, 1, 1), 1, res_word(0, 0, 0, 1, 8'h00, 0, 1));
        // running current action stays, highest handle queued
        add_row(req_word(REQ_ADD, 8'hFF, 1, 0, 1, 1), 1, res_word(0, 0, 1, 1, 8'h00, 1, 1));
        add_row(req_word(REQ_ADD, 8'h5A, 1, 0, 0, 1), 0, '0);
        add_row(req_word(REQ_ADD, 8'hA5, 1, 0, 1, 1), 0, '0);
        // flush stops the current one and the non-walkable entry
        add_row(req_word(REQ_FLUSH, 8'h00, 0, 0, 0, 0), 0, '0);
        // advance with an empty slot pulls the head even with running set
        add_row(req_word(REQ_ADVANCE, 8'h00, 0, 0, 0, 1), 0, '0);
        add_row(req_word(REQ_ADVANCE, 8'h00, 0, 0, 0, 1), 0, '0);
        add_row(req_word(REQ_ADD, 8'h81, 1, 0, 0, 1), 0, '0);
        // cancel: queue in order, then the current action
        add_row(req_word(REQ_CANCEL, 8'h00, 0, 0, 0, 0), 0, '0);
        // idle-only add on an idle block is taken
        add_row(req_word(REQ_ADD, 8'h3C, 1, 1, 1, 0), 1, res_word(0, 0, 1, 1, 8'h3C, 0, 1));
        // flush keeps a walkable current action, nothing to stop
        add_row(req_word(REQ_FLUSH, 8'h00, 0, 0, 0, 0), 1, res_word(0, 0, 0, 1, 8'h3C, 0, 1));
        // idle current with empty queue: slot empties silently
        add_row(req_word(REQ_ADVANCE, 8'h00, 0, 0, 0, 0), 1, res_word(0, 0, 0, 0, 0, 0, 1));
        // add with idle current drops it and pulls the head
        add_row(req_word(REQ_ADD, 8'h22, 1, 0, 0, 0), 0, '0);
        add_row(req_word(REQ_ADD, 8'h33, 1, 0, 0, 1), 0, '0);
        add_row(req_word(REQ_ADD, 8'h44, 1, 0, 0, 0), 0, '0);
        add_row(req_word(REQ_CANCEL, 8'h00, 0, 0, 0, 0), 0, '0);
        // flush over walkable slot and queue stops nothing
        add_row(req_word(REQ_ADD, 8'h66, 1, 0, 1, 0), 0, '0);
        add_row(req_word(REQ_ADD, 8'h77, 1, 0, 1, 1), 0, '0);
        add_row(req_word(REQ_FLUSH, 8'h00, 0, 0, 0, 0), 0, '0);
        add_row(req_word(REQ_CANCEL, 8'h00, 0, 0, 0, 0), 0, '0);
    endtask

    // fill bursts with random content, most closed by a control request, mixed with control and noise requests
    task automatic run_random_requests();
        int seq_no;
        int pick;
        int n;
        bit hold_current;
        seq_no = 0;
        while (n_sent < TOTAL_REQUESTS) begin
            pick = (seq_no == 0) ? 0 : $urandom_range(0, 9);
            if (pick <= 4) begin
                // the first burst is long enough to run the queue into its full state
                n = (seq_no == 0) ? 20 : $urandom_range(1, 20);
                hold_current = (seq_no == 0) || ($urandom_range(0, 1) == 1);
                repeat (n)
                    send_request(req_word(REQ_ADD, ID_W'($urandom_range(0, 255)),
                                          $urandom_range(0, 15) != 0,
                                          $urandom_range(0, 7) == 0,
                                          1'($urandom_range(0, 1)),
                                          hold_current || ($urandom_range(0, 3) != 0)),
                                 1'b0, '0);
                case ($urandom_range(0, 3))
                    0: send_request(rand_req(REQ_CANCEL), 1'b0, '0);
                    1: send_request(rand_req(REQ_FLUSH), 1'b0, '0);
                    2: repeat ($urandom_range(1, 4))
                           send_request(rand_req(REQ_ADVANCE), 1'b0, '0);
                    default: ;
                endcase
            end else if (pick <= 6) begin
                repeat ($urandom_range(1, 5))
                    send_request(rand_req(REQ_ADVANCE), 1'b0, '0);
            end else if (pick == 7) begin
                send_request(rand_req(REQ_FLUSH), 1'b0, '0);
            end else if (pick == 8) begin
                send_request(rand_req(REQ_CANCEL), 1'b0, '0);
            end else begin
                // noise: anything at all
                repeat ($urandom_range(1, 8))
                    send_request(rand_req(t_req_type'($urandom_range(0, 3))), 1'b0, '0);
            end
            seq_no++;
        end
    endtask

    // ------------------------------------------------------------------------
    // main flow: reset, directed table, random part, drain
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n      <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        n_sent         = 0;
        n_mismatch     = 0;
        sender_quiet   = 1'b0;
        shadow_count   = 0;
        slot_valid     = 1'b0;
        slot_id        = '0;
        slot_walk      = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        load_directed_rows();
        foreach (plan[r])
            send_request(plan[r].req, plan[r].typed, plan[r].want);
        run_random_requests();
        req_if.valid <= 1'b0;

        // every owed word must come out; the watchdog bounds this wait
        while (expected_words.size() != 0)
            @(posedge i_clk);
        // anything extra shows up here as a word with nothing expected
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (n_mismatch == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------------
    // result side, with random stalls and one long hold
    // ------------------------------------------------------------------------
    initial begin
        int   gap;
        t_res got;
        res_if.ready  <= 1'b0;
        n_got          = 0;
        receiver_quiet = 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            gap = receiver_quiet ? 0 : $urandom_range(0, MAX_GAP);
            // long hold lets the block back up into the request side
            if (n_got == HOLD_AT_WORD)
                gap = LONG_HOLD;
            if (gap > 0) begin
                res_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(negedge i_clk); while (!res_if.valid);
            got = res_if.data;
            @(posedge i_clk);
            check_word(got);
            n_got++;
            if (n_got % MODE_SPAN == 0)
                receiver_quiet = ($urandom_range(0, 3) == 0);
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too many cycles in a row with no word moving on either side
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (req_if.valid && req_if.ready) ||
            (res_if.valid && res_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
